// File: src/lpr_pkg.sv
// Shared types and constants for the line and point rasterizer.
package lpr_pkg;

  localparam int LPR_FIELD_W   = 16;  // coordinate field width on the ports
  localparam int LPR_PIX_W     = LPR_FIELD_W + 1;  // room for stamp overhang
  localparam int LPR_CFG_W     = 13;
  localparam int LPR_COLOR_W   = 8;
  localparam int LPR_INDEX_W   = 24;
  localparam int LPR_OP_W      = 2;
  localparam int LPR_CFG_IDX_W = 3;
  localparam int LPR_IN_DATA_W  = 4 * LPR_FIELD_W;
  localparam int LPR_OUT_DATA_W = 88;

  localparam int LPR_COORD_BITS_DEF   = 16;
  localparam int LPR_STAMP_RADIUS_DEF = 2;

  localparam logic [LPR_CFG_W-1:0]   LPR_WIDTH_RST  = 13'd640;
  localparam logic [LPR_CFG_W-1:0]   LPR_HEIGHT_RST = 13'd480;
  localparam logic [LPR_COLOR_W-1:0] LPR_COLOR_RST  = 8'd255;

  typedef enum logic [LPR_OP_W-1:0] {
    OP_LINE  = 2'd0,
    OP_POINT = 2'd1,
    OP_STEP  = 2'd2
  } lpr_op_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_POINT = 2'd2
  } lpr_mode_t;

  typedef enum logic [LPR_CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_RED    = 3'd2,
    CFG_GREEN  = 3'd3,
    CFG_BLUE   = 3'd4
  } lpr_cfg_idx_t;

  typedef struct packed {
    logic [LPR_CFG_W-1:0]   width;
    logic [LPR_CFG_W-1:0]   height;
    logic [LPR_COLOR_W-1:0] red;
    logic [LPR_COLOR_W-1:0] green;
    logic [LPR_COLOR_W-1:0] blue;
  } lpr_cfg_t;

  typedef struct packed {
    logic signed [LPR_PIX_W-1:0] x;
    logic signed [LPR_PIX_W-1:0] y;
    logic                        last;
  } lpr_pix_t;

endpackage

// File: src/line_and_point_rasterizer_top.sv
// Top level of the line and point rasterizer.
// A step beat's pixel is held in the walker pixel register, then in the formatter
//   output register, before it shows on the out_ channel.
// Throughput: one beat per cycle in, one pixel per cycle out while out_tready stays high; loads emit nothing.
// Reset (rst_n low, synchronous): walker goes idle, both pixel stages empty,
//   width/height back to 640/480 and all color components to 255.
module line_and_point_rasterizer_top #(
  parameter int COORD_BITS   = lpr_pkg::LPR_COORD_BITS_DEF,
  parameter int STAMP_RADIUS = lpr_pkg::LPR_STAMP_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input item stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // from bit 0: x_start[15:0], y_start[31:16], x_end[47:32], y_end[63:48]
  input  logic [lpr_pkg::LPR_IN_DATA_W-1:0]   in_tdata,
  // op: 0 load line, 1 load point, 2 step
  input  logic [lpr_pkg::LPR_OP_W-1:0]        in_tuser,
  // Pixel stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // from bit 0: pix_x[15:0], pix_y[31:16], in_bounds[32], pixel_index[56:33],
  // red[64:57], green[72:65], blue[80:73], zero pad to 88 bits
  output logic [lpr_pkg::LPR_OUT_DATA_W-1:0]  out_tdata,
  output logic                                out_tlast,
  // Register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpr_pkg::LPR_CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpr_pkg::LPR_CFG_W-1:0]       cfg_data
);
  import lpr_pkg::*;

  lpr_cfg_t cfg_r;
  logic     walk_adv;
  logic     fmt_adv;
  logic     pix_valid;
  lpr_pix_t pix;

  // Registers are always writable; the host must only write them while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= LPR_WIDTH_RST;
      cfg_r.height <= LPR_HEIGHT_RST;
      cfg_r.red    <= LPR_COLOR_RST;
      cfg_r.green  <= LPR_COLOR_RST;
      cfg_r.blue   <= LPR_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (lpr_cfg_idx_t'(cfg_index))
        CFG_WIDTH:  cfg_r.width  <= cfg_data;
        CFG_HEIGHT: cfg_r.height <= cfg_data;
        CFG_RED:    cfg_r.red    <= cfg_data[LPR_COLOR_W-1:0];
        CFG_GREEN:  cfg_r.green  <= cfg_data[LPR_COLOR_W-1:0];
        CFG_BLUE:   cfg_r.blue   <= cfg_data[LPR_COLOR_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Stage 1 advances when its pixel register is empty or moves on to stage 2.
  assign walk_adv  = !pix_valid || fmt_adv;
  assign in_tready = walk_adv;

  lpr_walker #(
    .COORD_BITS   (COORD_BITS),
    .STAMP_RADIUS (STAMP_RADIUS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (walk_adv),
    .in_valid  (in_tvalid),
    .op        (in_tuser),
    .x_start   (in_tdata[LPR_FIELD_W-1:0]),
    .y_start   (in_tdata[2*LPR_FIELD_W-1:LPR_FIELD_W]),
    .x_end     (in_tdata[3*LPR_FIELD_W-1:2*LPR_FIELD_W]),
    .y_end     (in_tdata[4*LPR_FIELD_W-1:3*LPR_FIELD_W]),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  // Stage 2: clip, index multiply, color, hold until the sink takes it.
  lpr_pixel_fmt u_fmt (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix_valid),
    .pix        (pix),
    .cfg        (cfg_r),
    .adv        (fmt_adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // An empty output register never stalls the input side.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // A clipped pixel carries a zero index.
  a_clip_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[56:33] == '0)
    else $error("clipped pixel with nonzero index");

  // A pixel moving out of stage 1 lands in the output register.
  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    pix_valid && fmt_adv |=> out_tvalid)
    else $error("pixel lost between stages");

endmodule

// File: src/lpr_walker.sv
// Primitive walker: Bresenham line stepper and square stamp scanner.
module lpr_walker #(
  parameter int COORD_BITS   = lpr_pkg::LPR_COORD_BITS_DEF,
  parameter int STAMP_RADIUS = lpr_pkg::LPR_STAMP_RADIUS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic [lpr_pkg::LPR_OP_W-1:0]     op,
  input  logic [lpr_pkg::LPR_FIELD_W-1:0]  x_start,
  input  logic [lpr_pkg::LPR_FIELD_W-1:0]  y_start,
  input  logic [lpr_pkg::LPR_FIELD_W-1:0]  x_end,
  input  logic [lpr_pkg::LPR_FIELD_W-1:0]  y_end,
  output logic                             pix_valid,
  output lpr_pkg::lpr_pix_t                pix
);
  import lpr_pkg::*;

  localparam int CW   = (COORD_BITS < LPR_FIELD_W) ? COORD_BITS : LPR_FIELD_W;
  localparam int EW   = CW + 4;
  localparam int SIDE = 2 * STAMP_RADIUS + 1;
  localparam int SW   = $clog2(SIDE + 1);
  localparam logic [SW-1:0] LAST_IDX = SW'(SIDE - 1);

  lpr_mode_t mode_r, mode_nxt;
  logic signed [CW-1:0]   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CW-1:0]   target_x_r, target_x_nxt, target_y_r, target_y_nxt;
  logic        [CW:0]     span_x_r, span_x_nxt;
  logic signed [CW+1:0]   neg_span_y_r, neg_span_y_nxt;
  logic signed [CW+2:0]   err_r, err_nxt;
  logic                   dir_x_r, dir_x_nxt, dir_y_r, dir_y_nxt;
  logic [SW-1:0]          col_r, col_nxt, row_r, row_nxt;
  logic                   pix_valid_r, pix_valid_nxt;
  lpr_pix_t               pix_r, pix_nxt;

  logic                   accept;
  lpr_op_t                op_e;
  logic signed [CW-1:0]   xs, ys, xe, ye;
  logic signed [CW:0]     dx, dy;
  logic signed [EW-1:0]   e2, sx_e, nsy_e, err_e;
  logic                   step_x, step_y, line_last, stamp_last;

  assign accept = in_valid && adv;
  assign op_e   = lpr_op_t'(op);
  assign xs     = x_start[CW-1:0];
  assign ys     = y_start[CW-1:0];
  assign xe     = x_end[CW-1:0];
  assign ye     = y_end[CW-1:0];
  assign dx     = (CW+1)'(xe) - (CW+1)'(xs);
  assign dy     = (CW+1)'(ye) - (CW+1)'(ys);

  assign err_e  = EW'(err_r);
  assign e2     = err_e <<< 1;
  assign sx_e   = signed'(EW'(span_x_r));
  assign nsy_e  = EW'(neg_span_y_r);
  assign step_x = (e2 >= nsy_e);
  assign step_y = (e2 <= sx_e);

  assign line_last  = (cur_x_r == target_x_r) && (cur_y_r == target_y_r);
  assign stamp_last = (col_r == LAST_IDX) && (row_r == LAST_IDX);

  // Next state
  always_comb begin
    mode_nxt       = mode_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    target_x_nxt   = target_x_r;
    target_y_nxt   = target_y_r;
    span_x_nxt     = span_x_r;
    neg_span_y_nxt = neg_span_y_r;
    err_nxt        = err_r;
    dir_x_nxt      = dir_x_r;
    dir_y_nxt      = dir_y_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    if (accept) begin
      case (op_e)
        OP_LINE: begin
          cur_x_nxt      = xs;
          cur_y_nxt      = ys;
          target_x_nxt   = xe;
          target_y_nxt   = ye;
          span_x_nxt     = dx[CW] ? -dx : dx;
          neg_span_y_nxt = dy[CW] ? (CW+2)'(dy) : -(CW+2)'(dy);
          err_nxt        = (CW+3)'(signed'({1'b0, span_x_nxt})) + (CW+3)'(neg_span_y_nxt);
          dir_x_nxt      = !(xs < xe);
          dir_y_nxt      = !(ys < ye);
          mode_nxt       = MODE_LINE;
        end
        OP_POINT: begin
          target_x_nxt = xs;
          target_y_nxt = ys;
          col_nxt      = '0;
          row_nxt      = '0;
          mode_nxt     = MODE_POINT;
        end
        OP_STEP: begin
          case (mode_r)
            MODE_LINE: begin
              if (line_last) begin
                mode_nxt = MODE_IDLE;
              end else begin
                err_nxt = (CW+3)'(err_e + (step_x ? nsy_e : '0) + (step_y ? sx_e : '0));
                if (step_x) cur_x_nxt = cur_x_r + (dir_x_r ? {CW{1'b1}} : CW'(1));
                if (step_y) cur_y_nxt = cur_y_r + (dir_y_r ? {CW{1'b1}} : CW'(1));
              end
            end
            MODE_POINT: begin
              if (stamp_last) begin
                mode_nxt = MODE_IDLE;
                col_nxt  = '0;
                row_nxt  = '0;
              end else if (row_r == LAST_IDX) begin
                row_nxt = '0;
                col_nxt = col_r + SW'(1);
              end else begin
                row_nxt = row_r + SW'(1);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Pixel emission
  always_comb begin
    pix_valid_nxt = accept && (op_e == OP_STEP) && (mode_r != MODE_IDLE);
    case (mode_r)
      MODE_POINT: begin
        pix_nxt.x    = LPR_PIX_W'(target_x_r) - LPR_PIX_W'(STAMP_RADIUS) + LPR_PIX_W'(col_r);
        pix_nxt.y    = LPR_PIX_W'(target_y_r) - LPR_PIX_W'(STAMP_RADIUS) + LPR_PIX_W'(row_r);
        pix_nxt.last = stamp_last;
      end
      default: begin
        pix_nxt.x    = LPR_PIX_W'(cur_x_r);
        pix_nxt.y    = LPR_PIX_W'(cur_y_r);
        pix_nxt.last = line_last;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      pix_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      if (adv) pix_valid_r <= pix_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    target_x_r   <= target_x_nxt;
    target_y_r   <= target_y_nxt;
    span_x_r     <= span_x_nxt;
    neg_span_y_r <= neg_span_y_nxt;
    err_r        <= err_nxt;
    dir_x_r      <= dir_x_nxt;
    dir_y_r      <= dir_y_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    if (adv) pix_r <= pix_nxt;
  end

  assign pix_valid = pix_valid_r;
  assign pix       = pix_r;

endmodule

// File: src/lpr_pixel_fmt.sv
// Pixel formatter: clip test, linear index, color and output register.
module lpr_pixel_fmt (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 pix_valid,
  input  lpr_pkg::lpr_pix_t                    pix,
  input  lpr_pkg::lpr_cfg_t                    cfg,
  output logic                                 adv,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lpr_pkg::LPR_OUT_DATA_W-1:0]   out_tdata,
  output logic                                 out_tlast
);
  import lpr_pkg::*;

  localparam int MAG_W  = LPR_PIX_W - 1;
  localparam int PROD_W = 2 * LPR_CFG_W;
  localparam int PAD_W  = LPR_OUT_DATA_W - (2 * LPR_FIELD_W + 1 + LPR_INDEX_W + 3 * LPR_COLOR_W);

  logic                             out_valid_r;
  logic [LPR_OUT_DATA_W-1:0]        data_r, data_nxt;
  logic                             last_r;
  logic                             in_b;
  logic [PROD_W-1:0]                prod, sum;
  logic [LPR_INDEX_W-1:0]           index;

  assign adv = !out_valid_r || out_tready;

  assign in_b = !pix.x[LPR_PIX_W-1] && !pix.y[LPR_PIX_W-1] &&
                (pix.x[MAG_W-1:0] < MAG_W'(cfg.width)) &&
                (pix.y[MAG_W-1:0] < MAG_W'(cfg.height));

  assign prod  = pix.y[LPR_CFG_W-1:0] * cfg.width;
  assign sum   = prod + PROD_W'(pix.x[LPR_CFG_W-1:0]);
  assign index = in_b ? sum[LPR_INDEX_W-1:0] : '0;

  assign data_nxt = {{PAD_W{1'b0}}, cfg.blue, cfg.green, cfg.red, index, in_b,
                     pix.y[LPR_FIELD_W-1:0], pix.x[LPR_FIELD_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
      last_r <= pix.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the line and point rasterizer.
module tb;
  import lpr_pkg::*;

  // Op code 3 is not decoded by the block; it must be dropped silently.
  localparam logic [LPR_OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STAMP_R    = LPR_STAMP_RADIUS_DEF;
  localparam int STAMP_SIDE = 2 * STAMP_R + 1;
  localparam int HOLD_LEN   = 300;   // long receiver hold-off, in cycles
  localparam int DRAIN_WAIT = 8;     // well past the walker and formatter pixel registers
  localparam int PHASE_BEATS = 270;

  typedef struct {
    logic [LPR_OP_W-1:0] op;
    logic [15:0]         xs, ys, xe, ye;
  } in_beat_t;

  typedef struct {
    logic [15:0] x, y;
    logic        inb;
    logic [23:0] idx;
    logic [7:0]  r, g, b;
    logic        last;
  } pixel_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [LPR_IN_DATA_W-1:0]  in_tdata  = '0;
  logic [LPR_OP_W-1:0]       in_tuser  = OP_STEP;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [LPR_OUT_DATA_W-1:0] out_tdata;
  logic                      out_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [LPR_CFG_IDX_W-1:0]  cfg_index = CFG_WIDTH;
  logic [LPR_CFG_W-1:0]      cfg_data  = '0;

  // Stimulus queue, expected pixel store and bookkeeping
  in_beat_t beats_to_send[$];
  pixel_t   pixels_due[$];
  in_beat_t next_beat;
  int       beats_queued = 0;
  int       beats_taken  = 0;
  int       mismatches   = 0;
  int       pix_seen     = 0;
  int       hold_left    = 0;
  int       next_hold_at = 150;
  bit       calm = 1'b0;         // no random idling on either side while set

  // Shadow of the register file
  logic [LPR_CFG_W-1:0]   scr_w = LPR_WIDTH_RST;
  logic [LPR_CFG_W-1:0]   scr_h = LPR_HEIGHT_RST;
  logic [LPR_COLOR_W-1:0] col_r = LPR_COLOR_RST;
  logic [LPR_COLOR_W-1:0] col_g = LPR_COLOR_RST;
  logic [LPR_COLOR_W-1:0] col_b = LPR_COLOR_RST;

  // Shadow of the walker state
  lpr_mode_t walk_mode = MODE_IDLE;
  int  cur_x = 0, cur_y = 0, tgt_x = 0, tgt_y = 0;
  int  span_x = 0, neg_span_y = 0, err_acc = 0;
  bit  dir_x = 1'b0, dir_y = 1'b0;
  int  stamp_col = 0, stamp_row = 0;

  line_and_point_rasterizer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit: far beyond the slowest legal run, holds and drains included.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel predictor
  // ---------------------------------------------------------------------------

  // Build one expected pixel: clip against the current screen, form the row
  // major index (wrapping to 24 bits) and attach the current color.
  function automatic void emit_pixel(input int x, input int y, input bit last);
    pixel_t p;
    int     w, h;
    longint lin;
    w = int'(scr_w);
    h = int'(scr_h);
    p.inb = (x >= 0) && (y >= 0) && (x < w) && (y < h);
    lin   = longint'(y) * w + x;
    p.idx = p.inb ? lin[23:0] : 24'd0;
    p.x = x[15:0];
    p.y = y[15:0];
    p.r = col_r;
    p.g = col_g;
    p.b = col_b;
    p.last = last;
    pixels_due.push_back(p);
  endfunction

  // Advance the shadow walker by one accepted input beat.
  function automatic void rasterize_beat(input logic [LPR_OP_W-1:0] op,
                                         input logic [LPR_IN_DATA_W-1:0] d);
    int xs, ys, xe, ye, dx, dy, e2;
    bit last;
    xs = $signed(d[15:0]);
    ys = $signed(d[31:16]);
    xe = $signed(d[47:32]);
    ye = $signed(d[63:48]);
    case (op)
      OP_LINE: begin
        dx = xe - xs;
        dy = ye - ys;
        cur_x = xs;
        cur_y = ys;
        tgt_x = xe;
        tgt_y = ye;
        span_x = (dx < 0) ? -dx : dx;
        neg_span_y = (dy < 0) ? dy : -dy;
        dir_x = !(xs < xe);
        dir_y = !(ys < ye);
        err_acc = span_x + neg_span_y;
        walk_mode = MODE_LINE;
      end
      OP_POINT: begin
        tgt_x = xs;
        tgt_y = ys;
        stamp_col = 0;
        stamp_row = 0;
        walk_mode = MODE_POINT;
      end
      OP_STEP: begin
        if (walk_mode == MODE_LINE) begin
          last = (cur_x == tgt_x) && (cur_y == tgt_y);
          emit_pixel(cur_x, cur_y, last);
          if (last) begin
            walk_mode = MODE_IDLE;
          end else begin
            // Both error updates use the doubled error from before the step.
            e2 = 2 * err_acc;
            if (e2 >= neg_span_y) begin
              err_acc += neg_span_y;
              cur_x += dir_x ? -1 : 1;
            end
            if (e2 <= span_x) begin
              err_acc += span_x;
              cur_y += dir_y ? -1 : 1;
            end
          end
        end else if (walk_mode == MODE_POINT) begin
          last = (stamp_col == STAMP_SIDE - 1) && (stamp_row == STAMP_SIDE - 1);
          emit_pixel(tgt_x - STAMP_R + stamp_col, tgt_y - STAMP_R + stamp_row, last);
          if (last) begin
            walk_mode = MODE_IDLE;
            stamp_col = 0;
            stamp_row = 0;
          end else if (stamp_row == STAMP_SIDE - 1) begin
            stamp_row = 0;
            stamp_col++;
          end else begin
            stamp_row++;
          end
        end
      end
      default: ;  // unused op: no pixel, no state change
    endcase
  endfunction

  function automatic void apply_reg(input logic [LPR_CFG_IDX_W-1:0] idx,
                                    input logic [LPR_CFG_W-1:0] val);
    case (idx)
      CFG_WIDTH:  scr_w = val;
      CFG_HEIGHT: scr_h = val;
      CFG_RED:    col_r = val[7:0];
      CFG_GREEN:  col_g = val[7:0];
      CFG_BLUE:   col_b = val[7:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: register writes, accepted items and accepted pixels
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      // Check the pixel first: an item taken at this edge cannot have made it.
      if (out_tvalid && out_tready) begin
        if (pixels_due.size() == 0) begin
          note_mismatch($sformatf("pixel x=0x%0h y=0x%0h with nothing expected",
                                  out_tdata[15:0], out_tdata[31:16]));
        end else begin
          want = pixels_due.pop_front();
          check_field("pix_x",       out_tdata[15:0],  want.x);
          check_field("pix_y",       out_tdata[31:16], want.y);
          check_field("in_bounds",   out_tdata[32],    want.inb);
          check_field("pixel_index", out_tdata[56:33], want.idx);
          check_field("red",         out_tdata[64:57], want.r);
          check_field("green",       out_tdata[72:65], want.g);
          check_field("blue",        out_tdata[80:73], want.b);
          check_field("last",        out_tlast,        want.last);
        end
      end
      if (in_tvalid && in_tready) begin
        rasterize_beat(in_tuser, in_tdata);
        beats_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: present the next queued beat once the current one is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (beats_to_send.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
        next_beat = beats_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_beat.op;
        in_tdata  <= {next_beat.ye, next_beat.xe, next_beat.ys, next_beat.xs};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off every few hundred
  // pixels so that the pipeline fills and in_tready must drop.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) pix_seen++;
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (pix_seen >= next_hold_at) begin
        hold_left = HOLD_LEN;
        next_hold_at += 700;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void push_beat(input logic [LPR_OP_W-1:0] op, input int xs,
                                    input int ys, input int xe, input int ye);
    in_beat_t b;
    b.op = op;
    b.xs = xs[15:0];
    b.ys = ys[15:0];
    b.xe = xe[15:0];
    b.ye = ye[15:0];
    beats_to_send.push_back(b);
    beats_queued++;
  endfunction

  function automatic int rand16();
    logic [15:0] v;
    v = 16'($urandom);
    return int'($signed(v));
  endfunction

  function automatic int clamp16(input int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // Mostly around the visible area, sometimes at the edges of the 16-bit range.
  function automatic int pick_coord(input int lim);
    int k;
    k = $urandom_range(99);
    if (k < 80) return $urandom_range(0, lim + 15) - 8;
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return -32767;
      2: return 32767;
      3: return 32766;
      default: return rand16();
    endcase
  endfunction

  // Steps carry don't-care data; randomize it anyway.
  function automatic void push_steps(input int n);
    for (int i = 0; i < n; i++) push_beat(OP_STEP, rand16(), rand16(), rand16(), rand16());
  endfunction

  // Trim a walk short (load-while-busy follows) or run past its end (idle steps).
  function automatic int vary_len(input int len);
    int k;
    k = $urandom_range(99);
    if (k < 15) return $urandom_range(0, len - 1);
    if (k < 25) return len + $urandom_range(1, 2);
    return len;
  endfunction

  task automatic add_sequence(input int w, input int h, output int added);
    int k, xs, ys, xe, ye, reach, len, n;
    int start_cnt;
    start_cnt = beats_queued;
    k = $urandom_range(99);
    if (k < 10) begin
      // Noise: unused op, stray step, or a load that the next one replaces
      case ($urandom_range(0, 2))
        0: push_beat(OP_UNUSED, rand16(), rand16(), rand16(), rand16());
        1: push_steps(1);
        default: push_beat($urandom_range(0, 1) ? OP_LINE : OP_POINT,
                           rand16(), rand16(), rand16(), rand16());
      endcase
    end else if (k < 14) begin
      // Huge span: walk a few pixels only
      push_beat(OP_LINE, rand16(), rand16(), rand16(), rand16());
      push_steps($urandom_range(1, 20));
    end else if (k < 57) begin
      xs = pick_coord(w);
      ys = pick_coord(h);
      reach = ($urandom_range(99) < 80) ? 12 : 60;
      xe = clamp16(xs + $urandom_range(0, 2 * reach) - reach);
      ye = clamp16(ys + $urandom_range(0, 2 * reach) - reach);
      push_beat(OP_LINE, xs, ys, xe, ye);
      len = ((xe > xs) ? xe - xs : xs - xe);
      n   = ((ye > ys) ? ye - ys : ys - ye);
      if (n > len) len = n;
      push_steps(vary_len(len + 1));
    end else begin
      push_beat(OP_POINT, pick_coord(w), pick_coord(h), rand16(), rand16());
      push_steps(vary_len(STAMP_SIDE * STAMP_SIDE));
    end
    added = beats_queued - start_cnt;
  endtask

  // Wait until every queued beat is taken and every pixel has come back,
  // then give loads and any late pixel time to settle.
  task automatic drain();
    while (beats_taken != beats_queued || pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input lpr_cfg_idx_t idx, input logic [LPR_CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Color writes carry random junk above bit 7; only the low byte counts.
  task automatic set_screen(input int w, input int h, input int r, input int g,
                            input int b);
    logic [4:0] junk;
    write_reg(CFG_WIDTH, w[12:0]);
    write_reg(CFG_HEIGHT, h[12:0]);
    junk = 5'($urandom);
    write_reg(CFG_RED, {junk, r[7:0]});
    junk = 5'($urandom);
    write_reg(CFG_GREEN, {junk, g[7:0]});
    junk = 5'($urandom);
    write_reg(CFG_BLUE, {junk, b[7:0]});
  endtask

  task automatic random_phase(input int w, input int h);
    int cnt, got;
    cnt = 0;
    while (cnt < PHASE_BEATS) begin
      add_sequence(w, h, got);
      cnt += got;
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset screen 640x480 and white
    push_steps(1);                                           // step while idle
    push_beat(OP_UNUSED, -1, -1, -1, -1);                    // unused op
    push_beat(OP_LINE, -32768, -32768, 32767, 32767);        // full-range diagonal
    push_steps(3);
    push_beat(OP_POINT, 32767, -32768, 0, 0);                // load while busy
    push_steps(3);
    push_beat(OP_LINE, 5, 5, 2, 4);                          // walks left and up
    push_steps(5);                                           // last one hits idle
    push_beat(OP_LINE, 10, 10, 10, 10);                      // single-pixel line
    push_steps(1);
    push_beat(OP_POINT, 0, 0, 0, 0);                         // clipped left column
    push_steps(5);
    push_beat(OP_LINE, 639, 479, 640, 480);                  // clip on far corner
    push_steps(2);
    drain();

    // Maximum screen, black: index wraps past 24 bits
    set_screen(8191, 8191, 0, 0, 0);
    random_phase(8191, 8191);

    // One-pixel screen, white, no idling on either side
    set_screen(1, 1, 255, 255, 255);
    calm <= 1'b1;
    random_phase(1, 1);
    calm <= 1'b0;

    // Zero-size screen: everything clipped
    set_screen(0, 0, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    random_phase(0, 0);

    set_screen(4096, 4096, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255));
    random_phase(4096, 4096);

    // Small screen: many lines straddle the edges
    set_screen(64, 48, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    random_phase(64, 48);

    begin
      int w, h;
      w = $urandom_range(1, 300);
      h = $urandom_range(1, 300);
      set_screen(w, h, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      random_phase(w, h);
    end

    // Catch late stray pixels before the verdict
    repeat (20) @(posedge clk);
    if (pixels_due.size() != 0) note_mismatch("expected pixels never arrived");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/lpr_pkg.sv
src/lpr_walker.sv
src/lpr_pixel_fmt.sv
src/line_and_point_rasterizer_top.sv
tb/sv/tb.sv
